// File: hw/rtl/mmbfa_pkg.sv
// Shared constants, codes and types of the bump frame allocator.
package mmbfa_pkg;

  localparam int ADDR_W    = 52;
  localparam int CMD_W     = 2;
  localparam int IDX_IN_W  = 5;
  localparam int CNT_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_AREAS_DEF   = 32;
  localparam int FRAME_BYTES_DEF = 4096;

  // Stream word layouts.
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 56;

  // Commands carried in in_tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Result status carried in out_tuser.
  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_AREA     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY       = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_STARTED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd3;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_ADJ,
    FSM_LIM,
    FSM_BASE,
    FSM_ROUND,
    FSM_SKIP_LO,
    FSM_SKIP_HI,
    FSM_ADV,
    FSM_DONE
  } state_t;

endpackage

// File: hw/rtl/memory_map_bump_frame_allocator.sv
// Bump frame allocator: command sequencer, memory-map table and shared address unit.
// From acceptance to out_tvalid: a load, an unused or a refused command goes straight to the result;
// a start or allocate first walks the table entries, skipping those behind the cursor, until the walk
// runs off the table or finds an area, then checks the reserved window; an allocate then advances.
// Throughput: one command at a time; in_tready returns as the result word is registered.
// Reset (rst_n, synchronous, active low) clears control state and configuration registers; no payload or table clear.
module memory_map_bump_frame_allocator
  import mmbfa_pkg::*;
#(
  parameter int MAX_AREAS   = MAX_AREAS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input words.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata from bit 0 up: entry_index[4:0], entry_base[51:0], entry_limit[51:0],
  // entry_available, two zero bits.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[1:0].
  input  logic [CMD_W-1:0]       in_tuser,
  // Result words.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata from bit 0 up: frame_address[51:0], four zero bits.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: status[1:0].
  output logic [STAT_W-1:0]      out_tuser,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data
);

  // Table address width, area counter width (it must hold MAX_AREAS itself) and
  // the widths used to compare narrow counts against MAX_AREAS.
  localparam int IDX_W  = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CA_W   = $clog2(MAX_AREAS + 1);
  localparam int CMP_W  = (CA_W > CNT_W) ? CA_W : CNT_W;
  localparam int LIDX_W = (CA_W > IDX_IN_W) ? CA_W : IDX_IN_W;
  localparam int ENT_W  = 2 * ADDR_W + 1;

  // Frame size is a power of two, so rounding up is an add and a mask.
  localparam logic [ADDR_W-1:0] FRAME_A  = ADDR_W'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] FRAME_M1 = ADDR_W'(FRAME_BYTES - 1);

  // Fields of the input word.
  logic [IDX_IN_W-1:0] in_index;
  logic [ADDR_W-1:0]   in_base;
  logic [ADDR_W-1:0]   in_limit;
  logic                in_avail;

  assign in_index = in_tdata[4:0];
  assign in_base  = in_tdata[56:5];
  assign in_limit = in_tdata[108:57];
  assign in_avail = in_tdata[109];

  // Configuration registers.
  logic [ADDR_W-1:0] kernel_end_r;
  logic [ADDR_W-1:0] reserved_base_r;
  logic [ADDR_W-1:0] reserved_limit_r;
  logic [CNT_W-1:0]  entry_count_r;

  // Sequencer and allocator state.
  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic              pass2_r, pass2_nxt;
  logic              started_r, started_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [CA_W-1:0]   ca_r, ca_nxt;
  logic [ADDR_W-1:0] frame_r, frame_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_frame_r, out_frame_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  logic in_fire;
  logic out_free;

  assign in_tready = (state_r == FSM_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign cfg_ready = 1'b1;

  // Effective entry count: values above the table size act as the table size.
  logic [CMP_W-1:0] count_ext;
  logic [CA_W-1:0]  live_n;

  assign count_ext = CMP_W'(entry_count_r);
  assign live_n    = (count_ext > CMP_W'(MAX_AREAS)) ? CA_W'(MAX_AREAS)
                                                      : CA_W'(entry_count_r);

  // Table writes come straight from an accepted load word; slots past the table are dropped.
  logic [LIDX_W-1:0] load_idx_ext;
  logic              tbl_we;
  logic              tbl_re;
  logic [ENT_W-1:0]  tbl_rdata;
  logic [ADDR_W-1:0] ent_base;
  logic [ADDR_W-1:0] ent_limit;
  logic              ent_usable;

  assign load_idx_ext = LIDX_W'(in_index);
  assign tbl_we       = in_fire && (in_tuser == CMD_LOAD) &&
                        (load_idx_ext < LIDX_W'(MAX_AREAS));
  assign tbl_re       = (state_r == FSM_ADJ);

  mmbfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_AREAS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (load_idx_ext[IDX_W-1:0]),
    .wdata ({in_base, in_limit, in_avail}),
    .re    (tbl_re),
    .raddr (ca_r[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  assign ent_base   = tbl_rdata[ENT_W-1 -: ADDR_W];
  assign ent_limit  = tbl_rdata[ADDR_W -: ADDR_W];
  assign ent_usable = tbl_rdata[0];

  // Shared address unit; the sequencer picks its operands each cycle.
  logic [ADDR_W-1:0] alu_a, alu_b, alu_c;
  logic [ADDR_W:0]   alu_sum;
  logic              alu_lt;

  mmbfa_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .op_c (alu_c),
    .sum  (alu_sum),
    .lt   (alu_lt)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    unique case (state_r)
      FSM_LIM: begin
        // Area lies behind when limit plus one frame is below the cursor.
        alu_a = ent_limit;
        alu_b = FRAME_A;
        alu_c = cursor_r;
      end
      FSM_BASE: begin
        alu_a = cursor_r;
        alu_c = ent_base;
      end
      FSM_ROUND: begin
        alu_a = ent_base;
        alu_b = FRAME_M1;
      end
      FSM_SKIP_LO: begin
        alu_a = cursor_r;
        alu_c = reserved_base_r;
      end
      FSM_SKIP_HI: begin
        alu_a = cursor_r;
        alu_c = reserved_limit_r;
      end
      FSM_ADV: begin
        alu_a = cursor_r;
        alu_b = FRAME_A;
      end
      default: begin
      end
    endcase
  end

  // Where the sequencer goes once an area holding the cursor has been found.
  state_t found_state;
  always_comb begin
    if (!pass2_r) begin
      found_state = FSM_SKIP_LO;
    end else if (cmd_r == CMD_START) begin
      found_state = FSM_DONE;
    end else begin
      found_state = FSM_ADV;
    end
  end

  // Where it goes when the cursor is not inside the reserved window: a start
  // still runs the second adjustment, an allocate hands out the cursor.
  state_t no_skip_state;
  assign no_skip_state = (cmd_r == CMD_START) ? FSM_ADJ : FSM_ADV;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          priority if (in_tuser == CMD_START) begin
            state_nxt = (live_n == '0) ? FSM_DONE : FSM_ADJ;
          end else if (in_tuser == CMD_ALLOC) begin
            state_nxt = (!started_r || live_n == '0) ? FSM_DONE : FSM_ADJ;
          end else begin
            state_nxt = FSM_DONE;
          end
        end
      end
      FSM_ADJ: begin
        state_nxt = (ca_r >= live_n) ? FSM_DONE : FSM_LIM;
      end
      FSM_LIM: begin
        state_nxt = alu_lt ? FSM_ADJ : FSM_BASE;
      end
      FSM_BASE: begin
        if (alu_lt) begin
          state_nxt = FSM_ROUND;
        end else begin
          state_nxt = ent_usable ? found_state : FSM_ADJ;
        end
      end
      FSM_ROUND: begin
        state_nxt = ent_usable ? found_state : FSM_ADJ;
      end
      FSM_SKIP_LO: begin
        state_nxt = alu_lt ? no_skip_state : FSM_SKIP_HI;
      end
      FSM_SKIP_HI: begin
        state_nxt = alu_lt ? FSM_ADJ : no_skip_state;
      end
      FSM_ADV: begin
        state_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    cmd_nxt        = cmd_r;
    pass2_nxt      = pass2_r;
    started_nxt    = started_r;
    cursor_nxt     = cursor_r;
    ca_nxt         = ca_r;
    frame_nxt      = frame_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_tuser;
          pass2_nxt  = 1'b0;
          frame_nxt  = '0;
          status_nxt = STAT_OK;
          if (in_tuser == CMD_START) begin
            started_nxt = 1'b0;
            cursor_nxt  = kernel_end_r;
            ca_nxt      = '0;
            if (live_n == '0) begin
              status_nxt = STAT_EMPTY;
            end
          end else if (in_tuser == CMD_ALLOC) begin
            if (!started_r) begin
              status_nxt = STAT_NOT_STARTED;
            end else if (live_n == '0) begin
              status_nxt = STAT_EMPTY;
            end
          end
        end
      end
      FSM_ADJ: begin
        // Walked off the end of the table; the index settles at the count.
        if (ca_r >= live_n) begin
          ca_nxt     = live_n;
          status_nxt = STAT_NO_AREA;
        end
      end
      FSM_LIM: begin
        if (alu_lt) begin
          ca_nxt = ca_r + CA_W'(1);
        end
      end
      FSM_BASE: begin
        if (!alu_lt) begin
          if (!ent_usable) begin
            ca_nxt = ca_r + CA_W'(1);
          end else if (pass2_r && cmd_r == CMD_START) begin
            started_nxt = 1'b1;
          end
        end
      end
      FSM_ROUND: begin
        cursor_nxt = alu_sum[ADDR_W-1:0] & ~FRAME_M1;
        if (!ent_usable) begin
          ca_nxt = ca_r + CA_W'(1);
        end else if (pass2_r && cmd_r == CMD_START) begin
          started_nxt = 1'b1;
        end
      end
      FSM_SKIP_LO: begin
        if (alu_lt && cmd_r == CMD_START) begin
          pass2_nxt = 1'b1;
        end
      end
      FSM_SKIP_HI: begin
        if (alu_lt) begin
          cursor_nxt = reserved_limit_r;
          pass2_nxt  = 1'b1;
        end else if (cmd_r == CMD_START) begin
          pass2_nxt = 1'b1;
        end
      end
      FSM_ADV: begin
        frame_nxt  = cursor_r;
        cursor_nxt = alu_sum[ADDR_W-1:0];
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = frame_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= FSM_IDLE;
      cmd_r            <= CMD_UNUSED;
      pass2_r          <= 1'b0;
      started_r        <= 1'b0;
      cursor_r         <= '0;
      ca_r             <= '0;
      status_r         <= STAT_OK;
      out_valid_r      <= 1'b0;
      kernel_end_r     <= '0;
      reserved_base_r  <= '0;
      reserved_limit_r <= '0;
      entry_count_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      pass2_r     <= pass2_nxt;
      started_r   <= started_nxt;
      cursor_r    <= cursor_nxt;
      ca_r        <= ca_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KERNEL_END:     kernel_end_r     <= cfg_data;
          CFG_RESERVED_BASE:  reserved_base_r  <= cfg_data;
          CFG_RESERVED_LIMIT: reserved_limit_r <= cfg_data;
          CFG_ENTRY_COUNT:    entry_count_r    <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    frame_r      <= frame_nxt;
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W){1'b0}}, out_frame_r};
  assign out_tuser  = out_status_r;

  // The area index never exceeds the table size.
  a_area_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ca_r <= CA_W'(MAX_AREAS))
    else $error("area index beyond table size");

  // Any error result carries a zero frame address.
  a_error_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata == '0))
    else $error("error result with nonzero frame address");

  // An accepted word always leaves the idle state behind.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while still idle afterward");

  // The allocator becomes started only at the end of a start command.
  a_started_by_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> (cmd_r == CMD_START) && (state_r == FSM_DONE))
    else $error("started set outside a start command");

endmodule

// File: hw/rtl/mmbfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/mmbfa_alu.sv
// Shared address unit: one wide add and one compare of the sum against a third operand.
module mmbfa_alu
  import mmbfa_pkg::*;
(
  input  logic [ADDR_W-1:0] op_a,
  input  logic [ADDR_W-1:0] op_b,
  input  logic [ADDR_W-1:0] op_c,
  output logic [ADDR_W:0]   sum,
  output logic              lt
);

  // The sum keeps its carry so that limit plus one frame compares without wrapping.
  assign sum = {1'b0, op_a} + {1'b0, op_b};
  assign lt  = (sum < {1'b0, op_c});

endmodule
